// File: hdl/lkvt_pkg.sv
// Shared types, codes and defaults for the linear key/value table.
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  // Default storage geometry
  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_VALUE_WIDTH = 64;

  // Fixed widths of the beat fields
  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int POS_W   = 8;
  localparam int ENTRY_W = 9;

  // Operation codes; the one unused code is handled by a default arm
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_UPSERT   = 3'd2,
    OP_ERASE    = 3'd3,
    OP_CONTAINS = 3'd4,
    OP_GET_KEY  = 3'd5,
    OP_GET_POS  = 3'd6
  } op_t;

  // Request beat
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  // Response beat
  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key_out;
    logic [VALUE_W-1:0] value_out;
    logic [ENTRY_W-1:0] entry_count;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_APPEND,
    S_UPDATE,
    S_MOVE,
    S_RESP
  } state_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LAST,
    RD_SLOT,
    RD_POS
  } rd_sel_t;

  // Write kind: append at the end, rewrite the matched slot, or move the last entry
  typedef enum logic [1:0] {
    WR_APPEND,
    WR_UPDATE,
    WR_MOVE
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan;
    logic    fetch;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ok_we;
    logic    ok_val;
    logic    res_load;
    logic    res_key;
    logic    res_val;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            scan_end;
    logic            full;
    logic            pos_ok;
    logic            ok;
    logic            out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/linear_key_value_table.sv
// Top level of the linear key/value table: controller plus datapath.
//
//  channel | signals                       | beat
//  --------+-------------------------------+---------------------------------------
//  request | req_valid, req_ready, req_data | operation, key, value, position
//  respond | rsp_valid, rsp_ready, rsp_data | ok, key_out, value_out, entry_count
//
// One request is worked at a time. The key search scans at most the entry count and reads
// one entry per cycle through a single memory read port and one comparator. Reset zeroes
// the entry count, scan state, outcome flag, response valid and controller state; the
// entry memories need no clearing. A stalled response holds in the output register while
// the next request is accepted; that request waits before its own response only if the
// first is unread.
`timescale 1ns / 1ps
`default_nettype none

module linear_key_value_table import lkvt_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp_data
);

  cmd_t    cmd;
  status_t status;

  lkvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lkvt_datapath #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

// File: hdl/lkvt_datapath.sv
// Datapath: request registers, entry memories, key scan, entry count and response register.
`timescale 1ns / 1ps
`default_nettype none

module lkvt_datapath import lkvt_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire     clk,
  input  wire     rst,
  input  req_t    req_data,
  input  cmd_t    cmd,
  output status_t status,
  output logic    rsp_valid,
  input  wire     rsp_ready,
  output rsp_t    rsp_data
);

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  // Entry memories
  logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];

  // Request registers
  logic [OP_W-1:0]        req_op;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [POS_W-1:0]       req_pos;

  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     scan_idx;
  logic                   pipe_valid;
  logic [ADDR_W-1:0]      pipe_idx;
  logic [ADDR_W-1:0]      slot;
  logic                   ok_flag;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;

  logic                   issue;
  logic                   mem_rd;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      last_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic                   hit;

  assign issue     = scan_idx < count;
  assign mem_rd    = (cmd.scan && issue) || cmd.fetch;
  assign last_addr = ADDR_W'(count - COUNT_W'(1));
  assign hit       = pipe_valid && (rd_key == req_key);

  // Pick the read address
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN: rd_addr = ADDR_W'(scan_idx);
      RD_LAST: rd_addr = last_addr;
      RD_SLOT: rd_addr = slot;
      RD_POS:  rd_addr = ADDR_W'(req_pos);
      default: rd_addr = ADDR_W'(scan_idx);
    endcase
  end

  // Pick the write address and data
  always_comb begin
    case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr  = ADDR_W'(count);
        wr_key   = req_key;
        wr_value = req_value;
      end
      WR_UPDATE: begin
        wr_addr  = slot;
        wr_key   = req_key;
        wr_value = req_value;
      end
      WR_MOVE: begin
        wr_addr  = slot;
        wr_key   = rd_key;
        wr_value = rd_value;
      end
      default: begin
        wr_addr  = slot;
        wr_key   = req_key;
        wr_value = req_value;
      end
    endcase
  end

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

  // Capture the request beat, masked to the stored widths
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= req_data.operation;
      req_key   <= KEY_WIDTH'(req_data.key);
      req_value <= VALUE_WIDTH'(req_data.value);
      req_pos   <= req_data.position;
    end
  end

  // Advance the scan; the valid tag is registered alongside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      pipe_valid <= 1'b0;
    end else if (cmd.load) begin
      scan_idx   <= '0;
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.scan && issue;
      if (cmd.scan && issue) begin
        scan_idx <= scan_idx + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= ADDR_W'(scan_idx);
    if (cmd.scan && hit) begin
      slot <= pipe_idx;
    end
  end

  // Outcome flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ok_flag <= 1'b0;
    end else if (cmd.load) begin
      ok_flag <= 1'b0;
    end else if (cmd.ok_we) begin
      ok_flag <= cmd.ok_val;
    end
  end

  // Entry count: grow on append, shrink on move
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_en && (cmd.wr_sel == WR_APPEND)) begin
      count <= count + COUNT_W'(1);
    end else if (cmd.wr_en && (cmd.wr_sel == WR_MOVE)) begin
      count <= count - COUNT_W'(1);
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_data.ok          <= ok_flag;
      rsp_data.key_out     <= cmd.res_key ? KEY_W'(rd_key) : '0;
      rsp_data.value_out   <= cmd.res_val ? VALUE_W'(rd_value) : '0;
      rsp_data.entry_count <= ENTRY_W'(count);
    end
  end

  // Status toward the controller
  assign status.op       = req_op;
  assign status.hit      = hit;
  assign status.scan_end = !pipe_valid && !issue;
  assign status.full     = count == COUNT_W'(CAPACITY);
  assign status.pos_ok   = CMP_W'(req_pos) < CMP_W'(count);
  assign status.ok       = ok_flag;
  assign status.out_free = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// File: hdl/lkvt_ctrl.sv
// Controller: sequences scan, read, write and response for one request at a time.
`timescale 1ns / 1ps
`default_nettype none

module lkvt_ctrl import lkvt_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   search_done;

  assign search_done = status.hit || status.scan_end;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.scan     = 1'b0;
    cmd.fetch    = 1'b0;
    cmd.rd_sel   = RD_SCAN;
    cmd.wr_en    = 1'b0;
    cmd.wr_sel   = WR_UPDATE;
    cmd.ok_we    = 1'b0;
    cmd.ok_val   = 1'b0;
    cmd.res_load = 1'b0;
    cmd.res_key  = 1'b0;
    cmd.res_val  = 1'b0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end

      // Walk the entries until a match or the end, then decide; position reads and unused codes decide at once
      S_SCAN: begin
        cmd.scan = 1'b1;
        case (status.op)
          OP_INSERT: begin
            if (search_done) begin
              cmd.ok_we  = 1'b1;
              cmd.ok_val = !status.hit && !status.full;
              state_next = (!status.hit && !status.full) ? S_APPEND : S_RESP;
            end
          end
          OP_UPDATE: begin
            if (search_done) begin
              cmd.ok_we  = 1'b1;
              cmd.ok_val = status.hit;
              state_next = status.hit ? S_UPDATE : S_RESP;
            end
          end
          OP_UPSERT: begin
            if (search_done) begin
              cmd.ok_we  = 1'b1;
              cmd.ok_val = status.hit || !status.full;
              if (status.hit) begin
                state_next = S_UPDATE;
              end else if (!status.full) begin
                state_next = S_APPEND;
              end else begin
                state_next = S_RESP;
              end
            end
          end
          OP_ERASE, OP_GET_KEY: begin
            if (search_done) begin
              cmd.ok_we  = 1'b1;
              cmd.ok_val = status.hit;
              state_next = status.hit ? S_FETCH : S_RESP;
            end
          end
          OP_CONTAINS: begin
            if (search_done) begin
              cmd.ok_we  = 1'b1;
              cmd.ok_val = status.hit;
              state_next = S_RESP;
            end
          end
          OP_GET_POS: begin
            cmd.ok_we  = 1'b1;
            cmd.ok_val = status.pos_ok;
            state_next = status.pos_ok ? S_FETCH : S_RESP;
          end
          default: begin
            cmd.ok_we  = 1'b1;
            cmd.ok_val = 1'b0;
            state_next = S_RESP;
          end
        endcase
      end

      // Read the last entry, the matched slot, or the named position
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (status.op == OP_ERASE) begin
          cmd.rd_sel = RD_LAST;
          state_next = S_MOVE;
        end else if (status.op == OP_GET_POS) begin
          cmd.rd_sel = RD_POS;
          state_next = S_RESP;
        end else begin
          cmd.rd_sel = RD_SLOT;
          state_next = S_RESP;
        end
      end

      S_APPEND: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_APPEND;
        state_next = S_RESP;
      end

      S_UPDATE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_UPDATE;
        state_next = S_RESP;
      end

      S_MOVE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        state_next = S_RESP;
      end

      // Hold until the response register is free
      S_RESP: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_key  = status.ok && (status.op == OP_GET_POS);
          cmd.res_val  = status.ok &&
                         ((status.op == OP_GET_POS) || (status.op == OP_GET_KEY));
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/lkvt_reply_checker.sv
// Reply checker for the linear key/value table: tracks table contents and scores each reply.
`timescale 1ns / 1ps

module lkvt_reply_checker import lkvt_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  input  wire  req_ready,
  input  req_t req_data,
  input  wire  rsp_valid,
  input  wire  rsp_ready,
  input  rsp_t rsp_data,
  output int   faults,
  output int   outstanding
);

  localparam int SLOTS      = DEF_CAPACITY;
  localparam int SHOW_LIMIT = 10;

  // Shadow copy of the table
  logic [KEY_W-1:0]   key_mem   [SLOTS];
  logic [VALUE_W-1:0] value_mem [SLOTS];
  int                 entry_total;

  // Replies owed by the block, oldest first
  rsp_t expected_replies [$];
  int   fault_total;

  // Apply one request to the shadow table and return the reply it should produce
  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t e;
    int   slot;
    int   i;
    e    = '0;
    slot = -1;
    // First match among live entries only
    for (i = 0; i < entry_total; i++) begin
      if (slot < 0 && key_mem[i] == r.key) slot = i;
    end
    case (op_t'(r.operation))
      OP_INSERT, OP_UPSERT: begin
        if (slot >= 0 && op_t'(r.operation) == OP_UPSERT) begin
          value_mem[slot] = r.value;
          e.ok = 1'b1;
        end else if (slot < 0 && entry_total < SLOTS) begin
          key_mem[entry_total]   = r.key;
          value_mem[entry_total] = r.value;
          entry_total++;
          e.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (slot >= 0) begin
          value_mem[slot] = r.value;
          e.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        // Fill the hole with the last entry
        if (slot >= 0) begin
          key_mem[slot]   = key_mem[entry_total-1];
          value_mem[slot] = value_mem[entry_total-1];
          entry_total--;
          e.ok = 1'b1;
        end
      end
      OP_CONTAINS: e.ok = (slot >= 0);
      OP_GET_KEY: begin
        if (slot >= 0) begin
          e.value_out = value_mem[slot];
          e.ok        = 1'b1;
        end
      end
      OP_GET_POS: begin
        if (int'(r.position) < entry_total) begin
          e.key_out   = key_mem[r.position];
          e.value_out = value_mem[r.position];
          e.ok        = 1'b1;
        end
      end
      default: ;
    endcase
    e.entry_count = ENTRY_W'(entry_total);
    return e;
  endfunction

  // Score reply beats, then queue the prediction for any accepted request
  always @(posedge clk) begin : score
    rsp_t want;
    if (rst) begin
      entry_total = 0;
      fault_total = 0;
      expected_replies.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          fault_total++;
          if (fault_total <= SHOW_LIMIT)
            $display("%0t: reply with nothing owed: ok=%0b key=%h value=%h count=%0d",
                     $time, rsp_data.ok, rsp_data.key_out, rsp_data.value_out,
                     rsp_data.entry_count);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_data.ok !== want.ok || rsp_data.key_out !== want.key_out ||
              rsp_data.value_out !== want.value_out ||
              rsp_data.entry_count !== want.entry_count) begin
            fault_total++;
            if (fault_total <= SHOW_LIMIT)
              $display("%0t: reply mismatch: want ok=%0b key=%h value=%h count=%0d",
                       $time, want.ok, want.key_out, want.value_out, want.entry_count,
                       "  got ok=%0b key=%h value=%h count=%0d",
                       rsp_data.ok, rsp_data.key_out, rsp_data.value_out,
                       rsp_data.entry_count);
          end
        end
      end
      if (req_valid && req_ready) expected_replies.push_back(apply_table_op(req_data));
    end
    faults      <= fault_total;
    outstanding <= expected_replies.size();
  end

endmodule

// File: verif/linear_key_value_table_tb.sv
// Testbench top for the linear key/value table: request stimulus, reply pacing and verdict.
`timescale 1ns / 1ps

module linear_key_value_table_tb;
  import lkvt_pkg::*;

  localparam int SLOTS        = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1500;
  localparam int RING         = 384;
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

  typedef enum {PH_GROW, PH_FULL, PH_SHRINK, PH_MIX} stage_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;
  int   faults;
  int   outstanding;

  // Key ring: inserts walk forward from ins_ptr, erases follow from del_ptr
  logic [KEY_W-1:0] key_ring [RING];
  int               ins_ptr;
  int               del_ptr;
  int               seen_count;
  int               burst_left;
  int               gap_max;

  linear_key_value_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  lkvt_reply_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .faults      (faults),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Track the entry count the block reports, to steer stimulus
  always @(posedge clk) begin
    if (rst) seen_count <= 0;
    else if (rsp_valid && rsp_ready) seen_count <= int'(rsp_data.entry_count);
  end

  function automatic req_t req_of(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                  input logic [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
    req_t r;
    r.operation = op;
    r.key       = k;
    r.value     = v;
    r.position  = p;
    return r;
  endfunction

  // Build one random request shaped by the current stage
  function automatic req_t pick_request(input stage_t stage);
    req_t r;
    int   span;
    int   roll;
    int   pick;
    r.operation = 3'($urandom_range(0, 7));
    r.key       = $urandom;
    r.value     = {$urandom, $urandom};
    r.position  = 8'($urandom_range(0, 255));
    span        = ins_ptr - del_ptr;
    roll        = $urandom_range(0, 99);
    if ((stage == PH_GROW && roll < 85) || (stage == PH_FULL && roll < 50)) begin
      r.operation = roll[0] ? OP_INSERT : OP_UPSERT;
      r.key       = key_ring[ins_ptr % RING];
      ins_ptr++;
    end else if (stage == PH_SHRINK && roll < 85 && span > 0) begin
      r.operation = OP_ERASE;
      r.key       = key_ring[del_ptr % RING];
      del_ptr++;
    end else begin
      // Mixed traffic: mostly keys likely present, some near misses, some noise
      pick = $urandom_range(0, 99);
      if (pick < 60 && span > 0) r.key = key_ring[(del_ptr + $urandom_range(0, span - 1)) % RING];
      else if (pick < 80) r.key = key_ring[$urandom_range(0, RING - 1)];
      if (r.operation == OP_GET_POS && $urandom_range(0, 9) < 7)
        r.position = 8'($urandom_range(0, (seen_count > 255) ? 255 : seen_count));
    end
    return r;
  endfunction

  // Offer one beat; idle between bursts, hold valid steady until accepted
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req_data  = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    @(negedge clk);
  endtask

  // Reply pacing: random stall modes plus one long hold-off to back the block up
  initial begin
    int cyc;
    int mode;
    int mode_left;
    rsp_ready = 1'b0;
    cyc       = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (!rst) cyc++;
      if (cyc == HOLD_AT) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (mode)
        0:       rsp_ready = 1'b1;
        1:       rsp_ready = 1'($urandom_range(0, 1));
        2:       rsp_ready = (cyc % 4 == 0);
        default: rsp_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Hard stop if the run hangs
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    stage_t stage;
    int     stage_items;
    int     i;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_data   = '0;
    ins_ptr    = 0;
    del_ptr    = 0;
    burst_left = 0;
    gap_max    = 4;
    for (i = 0; i < RING; i++) key_ring[i] = $urandom;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, key and value extremes, every op, hit and miss cases
    send_request(req_of(OP_GET_POS,  32'h0000_0000, '0, 8'd0));
    send_request(req_of(OP_ERASE,    32'h0000_0000, '0, 8'd0));
    send_request(req_of(OP_INSERT,   32'h0000_0000, 64'h0, 8'd0));
    send_request(req_of(OP_INSERT,   32'hFFFF_FFFF, '1, 8'hFF));
    send_request(req_of(OP_INSERT,   32'h0000_0000, 64'h1234, 8'd0));
    send_request(req_of(OP_UPDATE,   32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0));
    send_request(req_of(OP_UPDATE,   32'h1234_5678, 64'h1, 8'd0));
    send_request(req_of(OP_UPSERT,   32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 8'd0));
    send_request(req_of(OP_UPSERT,   32'h8000_0000, 64'h8000_0000_0000_0000, 8'd0));
    send_request(req_of(OP_CONTAINS, 32'h8000_0000, '0, 8'd0));
    send_request(req_of(OP_CONTAINS, 32'h7FFF_FFFF, '0, 8'd0));
    send_request(req_of(OP_GET_KEY,  32'h0000_0000, '1, 8'd0));
    send_request(req_of(OP_GET_KEY,  32'h0000_0001, '0, 8'd0));
    send_request(req_of(OP_GET_POS,  32'h0000_0000, '0, 8'd2));
    send_request(req_of(OP_GET_POS,  32'h0000_0000, '0, 8'd3));
    send_request(req_of(OP_GET_POS,  32'hFFFF_FFFF, '0, 8'hFF));
    send_request(req_of(OP_RESERVED, 32'hFFFF_FFFF, '1, 8'hFF));
    send_request(req_of(OP_INSERT,   32'h0000_0001, 64'h0123_4567_89AB_CDEF, 8'd0));
    send_request(req_of(OP_ERASE,    32'h0000_0000, '0, 8'd0));
    send_request(req_of(OP_ERASE,    32'h8000_0000, '0, 8'd0));
    send_request(req_of(OP_GET_POS,  32'h0000_0000, '0, 8'd0));
    send_request(req_of(OP_ERASE,    32'h0000_0000, '0, 8'd0));

    // Random: grow to full, press on the full table, drain, then mixed traffic, in a loop
    stage       = PH_GROW;
    stage_items = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // Move to the next stage and restart its item count
      case (stage)
        PH_GROW: begin
          if (seen_count >= SLOTS || stage_items > 400) begin
            stage       = PH_FULL;
            stage_items = 0;
          end
        end
        PH_FULL: begin
          if (stage_items >= 40) begin
            stage       = PH_SHRINK;
            stage_items = 0;
          end
        end
        PH_SHRINK: begin
          if (seen_count <= 8 || del_ptr >= ins_ptr || stage_items > 400) begin
            stage       = PH_MIX;
            stage_items = 0;
          end
        end
        default: begin
          if (stage_items >= 150) begin
            stage       = PH_GROW;
            stage_items = 0;
          end
        end
      endcase
      stage_items++;
      send_request(pick_request(stage));
      if (stage_items > 0 && $urandom_range(0, 63) == 0)
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    req_valid = 1'b0;

    // Drain everything owed, then watch for strays
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
